// ----- design/packet_ring_queue_drop_oldest_top_assert.svh -----
// Assertion macros used by the packet ring queue datapath.
`ifndef PACKET_RING_QUEUE_DROP_OLDEST_TOP_ASSERT_SVH
`define PACKET_RING_QUEUE_DROP_OLDEST_TOP_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define PRQDO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A condition that, once seen, implies another in the following cycle.
`define PRQDO_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/prqdo_pkg.sv -----
// Types and constants shared by the packet ring queue controller and datapath.
package prqdo_pkg;

  // Item kinds carried by the input channel.
  typedef enum logic [1:0] {
    KindPush  = 2'd0,
    KindTake  = 2'd1,
    KindFlush = 2'd2
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatTooLong = 2'd1,
    StatEmpty   = 2'd2,
    StatDropped = 2'd3
  } status_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgSlotsInUse = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSlotBytes  = 1'b1;
  localparam int unsigned CfgDataW = 7;

  // Controller states.
  typedef enum logic [2:0] {
    StIdle    = 3'd0,
    StCopy    = 3'd1,
    StResult  = 3'd2,
    StTakeLen = 3'd3,
    StStream  = 3'd4
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    stage;
    logic    commit;
    logic    reject;
    logic    flush;
    logic    take_start;
    logic    len_load;
    logic    copy_run;
    logic    stream_run;
    logic    load_single;
    logic    pend_we;
    status_e pend_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stage_full;
    logic overflow;
    logic ring_full;
    logic ring_empty;
    logic copy_done;
    logic stream_done;
    logic out_free;
  } stat_t;

endpackage

// ----- design/prqdo_ctrl.sv -----
// Controller state machine of the packet ring queue.
module prqdo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        kind_i,
  input  logic              end_of_packet_i,
  input  prqdo_pkg::stat_t  stat_i,
  output prqdo_pkg::cmd_t   cmd_o
);

  prqdo_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prqdo_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != prqdo_pkg::StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.pend_status = prqdo_pkg::StatOk;
    case (state_q)
      prqdo_pkg::StIdle: begin
        if (in_valid_i) begin
          case (prqdo_pkg::kind_e'(kind_i))
            prqdo_pkg::KindPush: begin
              cmd_o.stage = 1'b1;
              if (end_of_packet_i) begin
                cmd_o.pend_we = 1'b1;
                if (stat_i.overflow || stat_i.stage_full) begin
                  cmd_o.reject = 1'b1;
                  cmd_o.pend_status = prqdo_pkg::StatTooLong;
                  state_d = prqdo_pkg::StResult;
                end else begin
                  cmd_o.commit = 1'b1;
                  cmd_o.pend_status = stat_i.ring_full ? prqdo_pkg::StatDropped
                                                       : prqdo_pkg::StatOk;
                  state_d = prqdo_pkg::StCopy;
                end
              end
            end
            prqdo_pkg::KindTake: begin
              if (stat_i.ring_empty) begin
                cmd_o.pend_we = 1'b1;
                cmd_o.pend_status = prqdo_pkg::StatEmpty;
                state_d = prqdo_pkg::StResult;
              end else begin
                cmd_o.take_start = 1'b1;
                state_d = prqdo_pkg::StTakeLen;
              end
            end
            prqdo_pkg::KindFlush: begin
              cmd_o.flush = 1'b1;
              cmd_o.pend_we = 1'b1;
              cmd_o.pend_status = prqdo_pkg::StatOk;
              state_d = prqdo_pkg::StResult;
            end
            default: begin
            end
          endcase
        end
      end
      prqdo_pkg::StCopy: begin
        cmd_o.copy_run = 1'b1;
        if (stat_i.copy_done) begin
          state_d = prqdo_pkg::StResult;
        end
      end
      prqdo_pkg::StResult: begin
        cmd_o.load_single = 1'b1;
        if (stat_i.out_free) begin
          state_d = prqdo_pkg::StIdle;
        end
      end
      prqdo_pkg::StTakeLen: begin
        cmd_o.len_load = 1'b1;
        state_d = prqdo_pkg::StStream;
      end
      prqdo_pkg::StStream: begin
        cmd_o.stream_run = 1'b1;
        if (stat_i.stream_done) begin
          state_d = prqdo_pkg::StIdle;
        end
      end
      default: begin
        state_d = prqdo_pkg::StIdle;
      end
    endcase
  end

endmodule

// ----- design/prqdo_dp.sv -----
// Datapath of the packet ring queue: storage, pointers, copy and stream engines, output register.
`include "packet_ring_queue_drop_oldest_top_assert.svh"

module prqdo_dp #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned SLOT_BYTES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [prqdo_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [prqdo_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [7:0]                       data_byte_i,
  input  prqdo_pkg::cmd_t                  cmd_i,
  output prqdo_pkg::stat_t                 stat_o,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic [1:0]                       status_o,
  output logic [7:0]                       out_byte_o,
  output logic                             byte_valid_o,
  output logic                             last_byte_o,
  output logic [4:0]                       stored_count_o
);

  localparam int unsigned SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NW  = $clog2(SLOTS + 1);
  localparam int unsigned BW  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int unsigned LW  = $clog2(SLOT_BYTES + 1);
  localparam int unsigned SlotDepth = SLOTS << BW;
  localparam int unsigned SlotsReset = (SLOTS < 16) ? SLOTS : 16;
  localparam int unsigned BytesReset = (SLOT_BYTES < 64) ? SLOT_BYTES : 64;

  // Storage.
  logic [7:0]    staging_mem [SLOT_BYTES];
  logic [7:0]    slot_mem    [SlotDepth];
  logic [LW-1:0] len_mem     [SLOTS];

  // Configuration and ring state.
  logic [NW-1:0]  slots_in_use_q;
  logic [LW-1:0]  slot_bytes_q;
  logic [SIW-1:0] read_slot_q, write_slot_q;
  logic [NW-1:0]  entry_count_q;
  logic [LW-1:0]  stg_len_q;
  logic           stg_ovf_q;

  // Copy engine.
  logic [SIW-1:0] copy_base_q;
  logic [LW-1:0]  copy_len_q, cp_rd_q, cp_widx_q;
  logic           cp_v_q;
  logic [7:0]     stg_rd_q;

  // Stream engine.
  logic [SIW-1:0] take_base_q;
  logic [LW-1:0]  len_rd_q, take_len_q, rs_idx_q;
  logic           rd_v_q, rd_last_q;
  logic [7:0]     slot_rd_q;

  // Output register.
  logic                out_valid_q;
  prqdo_pkg::status_e  out_status_q, pend_status_q;
  logic [7:0]          out_byte_q;
  logic                out_bvalid_q, out_last_q;
  logic [4:0]          out_count_q;

  logic           stage_full, ring_full, out_free, cp_more, rs_more, issue;
  logic           ld_stream, ld_single, ring_clear;
  logic [SIW-1:0] next_rd, next_wr;
  logic [4:0]     cfg_slots_raw;
  logic [6:0]     cfg_bytes_raw;
  logic [NW-1:0]  slots_sat;
  logic [LW-1:0]  bytes_sat;

  assign stage_full = !(stg_len_q < slot_bytes_q);
  assign ring_full  = (entry_count_q >= slots_in_use_q);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cp_more    = (cp_rd_q != copy_len_q);
  assign rs_more    = (rs_idx_q != take_len_q);
  assign issue      = cmd_i.stream_run && rs_more && (!rd_v_q || out_free);
  assign ld_stream  = cmd_i.stream_run && rd_v_q && out_free;
  assign ld_single  = cmd_i.load_single && out_free;
  assign ring_clear = cfg_we_i || cmd_i.flush;

  assign next_rd = ((int'(read_slot_q) + 1) >= int'(slots_in_use_q)) ? '0
                 : read_slot_q + SIW'(1);
  assign next_wr = ((int'(write_slot_q) + 1) >= int'(slots_in_use_q)) ? '0
                 : write_slot_q + SIW'(1);

  // Saturate written register values into their legal ranges.
  assign cfg_slots_raw = cfg_data_i[4:0];
  assign cfg_bytes_raw = cfg_data_i[6:0];
  assign slots_sat = (cfg_slots_raw == '0) ? NW'(1)
                   : (int'(cfg_slots_raw) > SLOTS) ? NW'(SLOTS) : NW'(cfg_slots_raw);
  assign bytes_sat = (cfg_bytes_raw == '0) ? LW'(1)
                   : (int'(cfg_bytes_raw) > SLOT_BYTES) ? LW'(SLOT_BYTES)
                   : LW'(cfg_bytes_raw);

  always_comb begin
    stat_o.stage_full  = stage_full;
    stat_o.overflow    = stg_ovf_q;
    stat_o.ring_full   = ring_full;
    stat_o.ring_empty  = (entry_count_q == '0);
    stat_o.copy_done   = !cp_more && !cp_v_q;
    stat_o.stream_done = rd_v_q && rd_last_q && out_free;
    stat_o.out_free    = out_free;
  end

  // Configuration, ring pointers and staging bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_in_use_q <= NW'(SlotsReset);
      slot_bytes_q   <= LW'(BytesReset);
      read_slot_q    <= '0;
      write_slot_q   <= '0;
      entry_count_q  <= '0;
      stg_len_q      <= '0;
      stg_ovf_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == prqdo_pkg::CfgSlotsInUse) begin
          slots_in_use_q <= slots_sat;
        end else begin
          slot_bytes_q <= bytes_sat;
        end
      end
      if (ring_clear) begin
        read_slot_q   <= '0;
        write_slot_q  <= '0;
        entry_count_q <= '0;
      end else if (cmd_i.commit) begin
        write_slot_q <= next_wr;
        if (ring_full) begin
          read_slot_q <= next_rd;
        end else begin
          entry_count_q <= entry_count_q + NW'(1);
        end
      end else if (cmd_i.take_start) begin
        read_slot_q   <= next_rd;
        entry_count_q <= entry_count_q - NW'(1);
      end
      if (ring_clear || cmd_i.commit || cmd_i.reject) begin
        stg_len_q <= '0;
        stg_ovf_q <= 1'b0;
      end else if (cmd_i.stage) begin
        if (stage_full) begin
          stg_ovf_q <= 1'b1;
        end else begin
          stg_len_q <= stg_len_q + LW'(1);
        end
      end
    end
  end

  // Copy and stream engine control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_base_q <= '0;
      copy_len_q  <= '0;
      cp_rd_q     <= '0;
      cp_widx_q   <= '0;
      cp_v_q      <= 1'b0;
      take_base_q <= '0;
      take_len_q  <= '0;
      rs_idx_q    <= '0;
      rd_v_q      <= 1'b0;
      rd_last_q   <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        copy_base_q <= write_slot_q;
        copy_len_q  <= stg_len_q + LW'(1);
        cp_rd_q     <= '0;
        cp_v_q      <= 1'b0;
      end else if (cmd_i.copy_run) begin
        cp_v_q <= cp_more;
        if (cp_more) begin
          cp_rd_q   <= cp_rd_q + LW'(1);
          cp_widx_q <= cp_rd_q;
        end
      end
      if (cmd_i.take_start) begin
        take_base_q <= read_slot_q;
      end
      if (cmd_i.len_load) begin
        take_len_q <= len_rd_q;
        rs_idx_q   <= '0;
        rd_v_q     <= 1'b0;
      end else begin
        rd_v_q <= issue || (rd_v_q && !out_free);
        if (issue) begin
          rs_idx_q  <= rs_idx_q + LW'(1);
          rd_last_q <= ((rs_idx_q + LW'(1)) == take_len_q);
        end
      end
    end
  end

  // Memories: one write and one registered read port each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.stage && !stage_full) begin
      staging_mem[stg_len_q[BW-1:0]] <= data_byte_i;
    end
    if (cmd_i.copy_run && cp_more) begin
      stg_rd_q <= staging_mem[cp_rd_q[BW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cp_v_q) begin
      slot_mem[{copy_base_q, cp_widx_q[BW-1:0]}] <= stg_rd_q;
    end
    if (issue) begin
      slot_rd_q <= slot_mem[{take_base_q, rs_idx_q[BW-1:0]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      len_mem[write_slot_q] <= stg_len_q + LW'(1);
    end
    if (cmd_i.take_start) begin
      len_rd_q <= len_mem[read_slot_q];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld_stream || ld_single) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_we) begin
      pend_status_q <= cmd_i.pend_status;
    end
    if (ld_stream) begin
      out_status_q <= prqdo_pkg::StatOk;
      out_byte_q   <= slot_rd_q;
      out_bvalid_q <= 1'b1;
      out_last_q   <= rd_last_q;
      out_count_q  <= 5'(entry_count_q);
    end else if (ld_single) begin
      out_status_q <= pend_status_q;
      out_byte_q   <= '0;
      out_bvalid_q <= 1'b0;
      out_last_q   <= 1'b1;
      out_count_q  <= 5'(entry_count_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_byte_o     = out_byte_q;
  assign byte_valid_o   = out_bvalid_q;
  assign last_byte_o    = out_last_q;
  assign stored_count_o = out_count_q;

  `PRQDO_ASSERT(a_count_bound, entry_count_q <= slots_in_use_q, "ring holds more packets than slots")
  `PRQDO_ASSERT(a_stage_bound, stg_len_q <= slot_bytes_q, "staging length beyond slot size")
  `PRQDO_ASSERT(a_copy_bound, !cp_v_q || (cp_widx_q < copy_len_q), "copy writes past packet")
  `PRQDO_ASSERT_NEXT(a_take_pops, cmd_i.take_start && !cfg_we_i, (entry_count_q + NW'(1)) == $past(entry_count_q), "take did not remove a packet")

endmodule

// ----- design/packet_ring_queue_drop_oldest_top.sv -----
// Top level of the packet ring queue that drops the oldest packet on overflow.
//
// Input items arrive on in_valid_i/in_stall_o, results leave on out_valid_o/out_stall_i;
// a transaction takes place at a rising edge with valid high and stall low.
// A push transaction stages one byte; the byte flagged end_of_packet_i commits the
// packet into the next ring slot (dropping the oldest one if the ring is full) or
// rejects it when it exceeded slot_bytes, and yields one status result.
// A take streams the oldest packet one byte per cycle when not stalled, or reports empty.
// A flush transaction empties the ring and yields one result.
// A push byte without end of packet is staged directly; the last byte of a committed
// packet starts a copy from the staging buffer into the slot memory through its single
// write port behind a registered read, followed by loading the status; a rejected push,
// an empty take and a flush load their status directly. A take first fetches the stored
// length, then reads each byte from the slot memory through a registered read before it
// enters the output register.
// The output register lets a result wait while the receiver stalls; a further
// transaction that needs it is accepted but then holds in_stall_o high until the pending
// result has been handed over.
// Reset (rst_ni low) empties the ring, sets min(SLOTS, 16) slots in use and min(SLOT_BYTES,
// 64)-byte slots; a configuration write also empties the ring and any partly staged packet.
module packet_ring_queue_drop_oldest_top #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned SLOT_BYTES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [prqdo_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [prqdo_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     kind_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           end_of_packet_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic [7:0]                     out_byte_o,
  output logic                           byte_valid_o,
  output logic                           last_byte_o,
  output logic [4:0]                     stored_count_o
);

  prqdo_pkg::cmd_t  cmd;
  prqdo_pkg::stat_t stat;

  // The controller sequences each transaction and issues commands to the datapath.
  prqdo_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .end_of_packet_i (end_of_packet_i),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  // The datapath holds the staging buffer, slot memory, ring pointers and output register.
  prqdo_dp #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .data_byte_i    (data_byte_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .last_byte_o    (last_byte_o),
    .stored_count_o (stored_count_o)
  );

endmodule
